/* rtl/teq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types, constants and pointer helpers for the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_BITS = 16;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS    = CNT_BITS + 1;

   // Field widths fixed by the interface
   localparam int TIME_BITS = 63;
   localparam int DELAY_BITS = 64;
   localparam int IN_HANDLE_BITS = 16;
   localparam int OUT_HANDLE_BITS = 16;
   localparam int WAIT_BITS = 54;

   // Time limits
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [TIME_BITS-1:0] WAIT_CAP = TIME_MAX / 63'd1000;

   typedef enum logic [0:0] {
      OP_POST = 1'b0,
      OP_POLL = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      STS_POSTED      = 3'd0,
      STS_FULL        = 3'd1,
      STS_DELIVERED   = 3'd2,
      STS_EMPTY       = 3'd3,
      STS_NOT_DUE     = 3'd4,
      STS_NOT_RUNNING = 3'd5
   } status_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic [TIME_BITS-1:0]        now_us;
      logic signed [DELAY_BITS-1:0] delay_us;
      logic [IN_HANDLE_BITS-1:0]   message_handle;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic [OUT_HANDLE_BITS-1:0] delivered_handle;
      logic [WAIT_BITS-1:0]       wait_us;
   } rsp_word_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   due_us;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POST_SUM,
      ST_POST_SCAN,
      ST_POLL_DIFF,
      ST_POLL_DONE,
      ST_REPLY
   } state_type;

   // Advance a ring pointer by one
   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] res;
      if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + 1'b1;
      end
      return res;
   endfunction

   // Step a ring pointer back by one
   function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] res;
      if (ptr == '0) begin
         res = PTR_BITS'(QUEUE_DEPTH - 1);
      end else begin
         res = ptr - 1'b1;
      end
      return res;
   endfunction

   // Ring pointer plus an entry count
   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [CNT_BITS-1:0] cnt);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(ptr) + SUM_BITS'(cnt);
      if (sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         sum = sum - SUM_BITS'(QUEUE_DEPTH);
      end
      return PTR_BITS'(sum);
   endfunction

endpackage

/* rtl/timed_event_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_top
// Time-ordered queue of message handles kept in a ring memory.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A post word computes its due time and
// is placed by an insertion walk from the tail of a ring memory (one read and
// one write port, registered read): every queued entry due later moves up one
// slot per cycle, and a post passes through the sum state, one scan step for
// each queued entry due strictly later plus the inserting step, and the reply
// state. A poll reads the head, subtracts and caps the wait in its diff and
// done states; a poll on a stopped or empty queue goes straight to the reply
// state. Equal due times leave in arrival order. A post to a full queue is
// answered with the full status from the sum state and dropped. The next word
// is accepted only once the previous result is loaded into the result
// register, and that register lets it be accepted while that result waits.
// Reset clears the state, run flag, pointers, count and output valid; entries
// are never read before they are written.
module timed_event_queue_top
   import teq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   // Ring memory
   entry_type queue_mem [QUEUE_DEPTH];
   entry_type mem_rd_ff;
   logic [PTR_BITS-1:0] rd_addr;
   logic                wr_en;
   logic [PTR_BITS-1:0] wr_addr;
   entry_type           wr_data;

   // Control and datapath registers
   state_type             state_ff, state_in;
   logic                  enabled_ff;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   left_ff, left_in;
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   req_word_type          req_ff;
   logic [TIME_BITS-1:0]  when_ff, when_in;
   logic [TIME_BITS-1:0]  diff_ff, diff_in;
   logic                  late_ff, late_in;
   rsp_word_type          res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff;

   logic                  req_fire;
   logic                  out_free;
   logic                  is_full;
   logic                  scan_insert;
   logic                  delay_pos;
   logic [TIME_BITS:0]    due_sum;
   logic [TIME_BITS:0]    head_diff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign is_full   = (count_ff == CNT_BITS'(QUEUE_DEPTH));

   // Due time: now plus a positive delay, saturated at the largest time
   assign delay_pos = !req_ff.delay_us[DELAY_BITS-1] && (req_ff.delay_us != '0);
   assign due_sum   = {1'b0, req_ff.now_us} + {1'b0, req_ff.delay_us[TIME_BITS-1:0]};

   // Head due time minus now; the top bit is the borrow
   assign head_diff = {1'b0, mem_rd_ff.due_us} - {1'b0, req_ff.now_us};

   // Stop the walk at the first entry due at or before the new one
   assign scan_insert = (left_ff == '0) || !(mem_rd_ff.due_us > when_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_word.opcode == OP_POST) begin
                  state_in = ST_POST_SUM;
               end else if (!enabled_ff || count_ff == '0) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_POLL_DIFF;
               end
            end
         end
         ST_POST_SUM: begin
            state_in = is_full ? ST_REPLY : ST_POST_SCAN;
         end
         ST_POST_SCAN: begin
            if (scan_insert) begin
               state_in = ST_REPLY;
            end
         end
         ST_POLL_DIFF: state_in = ST_POLL_DONE;
         ST_POLL_DONE: state_in = ST_REPLY;
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory control and result
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      wr_in        = wr_ff;
      when_in      = when_ff;
      diff_in      = diff_ff;
      late_in      = late_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_ff;
      wr_data      = '{due_us: when_ff, handle: HANDLE_BITS'(req_ff.message_handle)};
      case (state_ff)
         ST_IDLE: begin
            // Answer stopped or empty polls at once; else fetch the head
            rd_addr = head_ff;
            res_in  = '{status: STS_EMPTY, delivered_handle: '0, wait_us: '0};
            if (!enabled_ff) begin
               res_in.status = STS_NOT_RUNNING;
            end
         end
         ST_POST_SUM: begin
            // Latch the due time and fetch the last entry
            when_in = delay_pos ? (due_sum[TIME_BITS] ? TIME_MAX : due_sum[TIME_BITS-1:0])
                                : req_ff.now_us;
            rd_addr = ptr_dec(tail_ff);
            wr_in   = tail_ff;
            left_in = count_ff;
            res_in  = '{status: STS_FULL, delivered_handle: '0, wait_us: '0};
         end
         ST_POST_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = wr_ff;
            rd_addr = ptr_dec(ptr_dec(wr_ff));
            if (scan_insert) begin
               // Drop the new entry into the gap
               tail_in  = ptr_inc(tail_ff);
               count_in = count_ff + 1'b1;
               res_in   = '{status: STS_POSTED, delivered_handle: '0, wait_us: '0};
            end else begin
               // Move the later entry up one slot
               wr_data = mem_rd_ff;
               wr_in   = ptr_dec(wr_ff);
               left_in = left_ff - 1'b1;
            end
         end
         ST_POLL_DIFF: begin
            diff_in = head_diff[TIME_BITS-1:0];
            late_in = head_diff[TIME_BITS] || (head_diff == '0);
            res_in  = '{status: STS_DELIVERED,
                        delivered_handle: OUT_HANDLE_BITS'(mem_rd_ff.handle),
                        wait_us: '0};
         end
         ST_POLL_DONE: begin
            if (late_ff) begin
               // Pop the head
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
            end else begin
               res_in.status           = STS_NOT_DUE;
               res_in.delivered_handle = '0;
               res_in.wait_us = WAIT_BITS'((diff_ff > WAIT_CAP) ? WAIT_CAP : diff_ff);
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rd_addr = head_ff;
         end
      endcase
   end

   // Ring memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= queue_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            enabled_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_word;
      end
      if (state_ff == ST_REPLY && out_free) begin
         rsp_ff <= res_ff;
      end
      left_ff <= left_in;
      wr_ff   <= wr_in;
      when_ff <= when_in;
      diff_ff <= diff_in;
      late_ff <= late_in;
      res_ff  <= res_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      ptr_add(head_ff, count_ff) == tail_ff)
      else $error("tail pointer out of step with head and count");

   a_stopped_poll_keeps_queue: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_word.opcode == OP_POLL && !enabled_ff) |=>
         ($stable(count_ff) && $stable(head_ff)))
      else $error("poll on a stopped queue changed the queue");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST_SCAN && scan_insert) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the queue by one");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST_SUM && !is_full) |=> state_ff == ST_POST_SCAN)
      else $error("post refused on a queue with room");

endmodule
